@@ hw/rtl/cam_pkg.sv @@
// shared types and constants for the cigar alignment metrics block
package cam_pkg;

    localparam int unsigned ELEM_TYPE_W = 2;
    localparam int unsigned ELEM_LEN_W  = 16;
    localparam int unsigned OUT_W       = 32;
    localparam int unsigned NUM_TOT     = 5;

    // cigar operation codes
    localparam logic [ELEM_TYPE_W-1:0] OP_MATCH    = 2'd0;
    localparam logic [ELEM_TYPE_W-1:0] OP_MISMATCH = 2'd1;
    localparam logic [ELEM_TYPE_W-1:0] OP_INSERT   = 2'd2;
    localparam logic [ELEM_TYPE_W-1:0] OP_DELETE   = 2'd3;

    // what one element adds to a total
    typedef logic [1:0] t_inc;
    localparam t_inc INC_NONE = 2'd0;
    localparam t_inc INC_ONE  = 2'd1;
    localparam t_inc INC_LEN  = 2'd2;

    // total slots
    localparam int unsigned TOT_EVENT  = 0;
    localparam int unsigned TOT_EDIT   = 1;
    localparam int unsigned TOT_NOCLIP = 2;
    localparam int unsigned TOT_MATCH  = 3;
    localparam int unsigned TOT_SPAN   = 4;

    // classified element as it travels from front to back
    typedef struct packed {
        t_inc [NUM_TOT-1:0]    sel;
        logic [ELEM_LEN_W-1:0] len;
        logic                  last;
    } t_elem;

endpackage

@@ hw/rtl/cam_front.sv @@
// front end: accepts cigar elements and classifies each into per-total increments
module cam_front #(
    parameter int unsigned RUN_LENGTH_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [cam_pkg::ELEM_TYPE_W-1:0] i_elem_type,
    input  logic [cam_pkg::ELEM_LEN_W-1:0]  i_elem_length,
    input  logic                            i_is_last,
    input  logic                            i_q_full,
    output logic                            o_push,
    output cam_pkg::t_elem                  o_elem
);
    import cam_pkg::*;

    localparam int unsigned LEN_W =
        (RUN_LENGTH_BITS < ELEM_LEN_W) ? RUN_LENGTH_BITS : ELEM_LEN_W;

    logic r_at_first;
    logic n_at_first;
    logic clip;

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;
    assign clip       = r_at_first || i_is_last;

    always_comb begin
        o_elem.len  = ELEM_LEN_W'(i_elem_length[LEN_W-1:0]);
        o_elem.last = i_is_last;
        o_elem.sel  = {NUM_TOT{INC_NONE}};
        case (i_elem_type)
            OP_MATCH: begin
                o_elem.sel[TOT_MATCH] = INC_LEN;
                o_elem.sel[TOT_SPAN]  = INC_LEN;
            end
            OP_MISMATCH: begin
                o_elem.sel[TOT_EVENT]  = INC_ONE;
                o_elem.sel[TOT_EDIT]   = INC_ONE;
                o_elem.sel[TOT_NOCLIP] = INC_ONE;
                o_elem.sel[TOT_SPAN]   = INC_ONE;
            end
            OP_INSERT: begin
                o_elem.sel[TOT_EVENT]  = INC_ONE;
                o_elem.sel[TOT_EDIT]   = INC_LEN;
                o_elem.sel[TOT_NOCLIP] = INC_LEN;
                o_elem.sel[TOT_SPAN]   = INC_LEN;
            end
            OP_DELETE: begin
                o_elem.sel[TOT_EVENT]  = INC_ONE;
                o_elem.sel[TOT_EDIT]   = INC_LEN;
                // deletion at either end of the cigar is a clip
                o_elem.sel[TOT_NOCLIP] = clip ? INC_NONE : INC_LEN;
            end
            default: begin
                o_elem.sel = {NUM_TOT{INC_NONE}};
            end
        endcase
    end

    always_comb begin
        n_at_first = r_at_first;
        if (o_push) begin
            n_at_first = i_is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_first <= 1'b1;
        end else begin
            r_at_first <= n_at_first;
        end
    end

endmodule

@@ hw/rtl/cam_queue.sv @@
// short fifo of classified elements between front and back
module cam_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cam_pkg::t_elem i_elem,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output cam_pkg::t_elem o_elem
);
    import cam_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_elem            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_elem  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_elem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

@@ hw/rtl/cam_back.sv @@
// back end: saturating running totals and the result register
module cam_back #(
    parameter int unsigned TOTAL_BITS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_q_valid,
    input  cam_pkg::t_elem            i_elem,
    output logic                      o_pop,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [cam_pkg::OUT_W-1:0] o_event_count,
    output logic [cam_pkg::OUT_W-1:0] o_edit_total,
    output logic [cam_pkg::OUT_W-1:0] o_edit_total_no_clip,
    output logic [cam_pkg::OUT_W-1:0] o_matched_bases,
    output logic [cam_pkg::OUT_W-1:0] o_effective_span
);
    import cam_pkg::*;

    localparam int unsigned SUM_W = TOTAL_BITS + 1;
    localparam int unsigned EXT_W = (TOTAL_BITS >= OUT_W) ? TOTAL_BITS : OUT_W;

    logic [TOTAL_BITS-1:0] r_acc [NUM_TOT];
    logic [TOTAL_BITS-1:0] n_acc [NUM_TOT];
    logic [TOTAL_BITS-1:0] upd   [NUM_TOT];
    logic [ELEM_LEN_W-1:0] inc   [NUM_TOT];
    logic [SUM_W-1:0]      sum   [NUM_TOT];
    logic [EXT_W-1:0]      ext   [NUM_TOT];
    logic [OUT_W-1:0]      r_res [NUM_TOT];
    logic                  r_out_valid;
    logic                  n_out_valid;
    logic                  slot_free;
    logic                  emit;

    assign slot_free = !r_out_valid || !i_out_stall;
    // a last element waits until the result register can take it
    assign o_pop     = i_q_valid && (!i_elem.last || slot_free);
    assign emit      = o_pop && i_elem.last;

    always_comb begin
        for (int i = 0; i < NUM_TOT; i++) begin
            case (i_elem.sel[i])
                INC_ONE: inc[i] = ELEM_LEN_W'(1);
                INC_LEN: inc[i] = i_elem.len;
                default: inc[i] = '0;
            endcase
            sum[i] = {1'b0, r_acc[i]} + SUM_W'(inc[i]);
            // carry out means the total sticks at all ones
            upd[i] = sum[i][TOTAL_BITS] ? '1 : sum[i][TOTAL_BITS-1:0];
            ext[i] = EXT_W'(upd[i]);
            n_acc[i] = r_acc[i];
            if (o_pop) begin
                n_acc[i] = i_elem.last ? '0 : upd[i];
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_TOT; i++) begin
                r_acc[i] <= '0;
            end
        end else begin
            r_out_valid <= n_out_valid;
            for (int i = 0; i < NUM_TOT; i++) begin
                r_acc[i] <= n_acc[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            for (int i = 0; i < NUM_TOT; i++) begin
                r_res[i] <= ext[i][OUT_W-1:0];
            end
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_event_count        = r_res[TOT_EVENT];
    assign o_edit_total         = r_res[TOT_EDIT];
    assign o_edit_total_no_clip = r_res[TOT_NOCLIP];
    assign o_matched_bases      = r_res[TOT_MATCH];
    assign o_effective_span     = r_res[TOT_SPAN];

endmodule

@@ hw/rtl/cigar_alignment_metrics.sv @@
// top level of the cigar alignment metrics block
//
//   channel  | direction | handshake               | beat
//   ---------+-----------+-------------------------+----------------------------------
//   element  | in        | i_in_valid / o_in_stall | type, run length, last marker
//   result   | out       | o_out_valid/i_out_stall | five 32-bit totals, one per cigar
//
// one element per cycle sustained while the fifo has room; the back end retires
// an element per cycle unless held; a last element is popped into the result register.
// the element fifo (Q_DEPTH beats) stalls input only when full.
// a last element waits in the fifo while a previous result is still stalled.
// synchronous active-low reset clears totals, fifo and the result valid.
module cigar_alignment_metrics #(
    parameter int unsigned RUN_LENGTH_BITS = 16,
    parameter int unsigned TOTAL_BITS      = 32,
    parameter int unsigned Q_DEPTH         = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [cam_pkg::ELEM_TYPE_W-1:0] i_elem_type,
    input  logic [cam_pkg::ELEM_LEN_W-1:0]  i_elem_length,
    input  logic                            i_is_last,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [cam_pkg::OUT_W-1:0]       o_event_count,
    output logic [cam_pkg::OUT_W-1:0]       o_edit_total,
    output logic [cam_pkg::OUT_W-1:0]       o_edit_total_no_clip,
    output logic [cam_pkg::OUT_W-1:0]       o_matched_bases,
    output logic [cam_pkg::OUT_W-1:0]       o_effective_span
);
    import cam_pkg::*;

    logic  push;
    logic  q_full;
    logic  q_valid;
    logic  pop;
    t_elem front_elem;
    t_elem back_elem;

    cam_front #(
        .RUN_LENGTH_BITS(RUN_LENGTH_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_elem_type   (i_elem_type),
        .i_elem_length (i_elem_length),
        .i_is_last     (i_is_last),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_elem        (front_elem)
    );

    cam_queue #(
        .DEPTH(Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_elem  (front_elem),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_elem  (back_elem)
    );

    cam_back #(
        .TOTAL_BITS(TOTAL_BITS)
    ) u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_q_valid            (q_valid),
        .i_elem               (back_elem),
        .o_pop                (pop),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_event_count        (o_event_count),
        .o_edit_total         (o_edit_total),
        .o_edit_total_no_clip (o_edit_total_no_clip),
        .o_matched_bases      (o_matched_bases),
        .o_effective_span     (o_effective_span)
    );

endmodule

@@ hw/rtl/cam_checker.sv @@
// port-level checks for the cigar alignment metrics block, bound to the top level
module cam_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_in_stall,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic [cam_pkg::OUT_W-1:0] o_event_count,
    input logic [cam_pkg::OUT_W-1:0] o_edit_total,
    input logic [cam_pkg::OUT_W-1:0] o_edit_total_no_clip,
    input logic [cam_pkg::OUT_W-1:0] o_matched_bases,
    input logic [cam_pkg::OUT_W-1:0] o_effective_span
);
    import cam_pkg::*;

    // reset leaves no result pending
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // fifo is empty after reset, so input is never stalled then
    a_reset_in: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("input stalled right after reset");

    // a stalled result beat stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // a stalled result beat keeps its totals
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            $stable(o_event_count) && $stable(o_edit_total) &&
            $stable(o_edit_total_no_clip) && $stable(o_matched_bases) &&
            $stable(o_effective_span))
        else $error("result totals changed while stalled");

endmodule

bind cigar_alignment_metrics cam_checker u_cam_checker (.*);
